>>> design/signed_decimal_formatter_defines.svh
// Assertion macros shared by the formatter modules.
// Every module that uses them has a clock named clk and an active-low reset named rst_n.
`ifndef SIGNED_DECIMAL_FORMATTER_DEFINES_SVH
`define SIGNED_DECIMAL_FORMATTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sdf_pkg.sv
package sdf_pkg;

  // Fixed widths of the payload.
  localparam int VALUE_W = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 4;
  localparam int CHAR_W = 8;

  // The shift-and-add-3 unit consumes this many magnitude bits per cycle.
  localparam int BITS_PER_CYCLE = 4;
  localparam int CONV_CYCLES = VALUE_W / BITS_PER_CYCLE;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // One converted number as it travels from the front part to the back part.
  typedef struct packed {
    logic                                neg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
    logic [COUNT_W-1:0]                  ndig;
  } job_t;

  // Handshake between the job queue and either side.
  typedef struct packed {
    logic valid;
    logic full;
  } jq_status_t;

endpackage

>>> design/sdf_front.sv
module sdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_value,
  input  logic                jq_full,
  output logic                jq_push,
  output sdf_pkg::job_t       jq_job
);
  import sdf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;
  localparam int STEP_W = $clog2(CONV_CYCLES);

  logic [1:0]                          state_r, state_nxt;
  logic [STEP_W-1:0]                   step_r, step_nxt;
  logic [VALUE_W-1:0]                  bin_r, bin_nxt;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  bcd_r, bcd_nxt;
  logic                                neg_r, neg_nxt;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  dab_bcd;
  logic [VALUE_W-1:0]                  dab_bin;
  logic [VALUE_W-1:0]                  raw;
  logic [VALUE_W-1:0]                  mag;
  logic [COUNT_W-1:0]                  ndig;
  logic                                accept;

  assign raw = in_value;
  assign mag = raw[VALUE_W-1] ? (~raw + {{(VALUE_W-1){1'b0}}, 1'b1}) : raw;
  assign in_full = (state_r != ST_IDLE);
  assign accept = in_push && !in_full;

  // Shift-and-add-3 over BITS_PER_CYCLE magnitude bits: one group of bits per cycle.
  always_comb begin
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] b;
    logic [VALUE_W-1:0] m;
    b = bcd_r;
    m = bin_r;
    for (int s = 0; s < BITS_PER_CYCLE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d] >= 4'd5) begin
          b[d] = b[d] + 4'd3;
        end
      end
      {b, m} = {b, m} << 1;
    end
    dab_bcd = b;
    dab_bin = m;
  end

  // Number of significant digits, at least one so that zero prints.
  always_comb begin
    ndig = 4'd1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d] != '0) begin
        ndig = COUNT_W'(d + 1);
      end
    end
  end

  // Sequencer: take an item, convert it, then hand it to the queue.
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    jq_push = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          bin_nxt = mag;
          bcd_nxt = '0;
          neg_nxt = raw[VALUE_W-1];
          step_nxt = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bin_nxt = dab_bin;
        bcd_nxt = dab_bcd;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CONV_CYCLES - 1)) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!jq_full) begin
          jq_push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign jq_job.neg = neg_r;
  assign jq_job.digits = bcd_r;
  assign jq_job.ndig = ndig;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

>>> design/sdf_jobq.sv
`include "signed_decimal_formatter_defines.svh"

module sdf_jobq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sdf_pkg::job_t         push_job,
  input  logic                  pop,
  output sdf_pkg::job_t         head_job,
  output sdf_pkg::jq_status_t   status
);
  import sdf_pkg::*;

  // Two entries: the back part can work on one number while the next waits.
  job_t        mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push;
  logic        do_pop;

  assign status.valid = (count_r != 2'd0);
  assign status.full = (count_r == 2'd2);
  assign do_push = push && !status.full;
  assign do_pop = pop && status.valid;
  assign head_job = mem[rd_ptr_r];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  `SDF_ASSERT_SAME(a_jq_level, 1'b1, count_r != 2'd3, "job queue level out of range")
  `SDF_ASSERT_SAME(a_jq_ptrs, (count_r == 2'd0) || (count_r == 2'd2), wr_ptr_r == rd_ptr_r, "job queue pointers disagree with level")
  `SDF_ASSERT_NEXT(a_jq_fill, do_push && !do_pop && (count_r == 2'd1), status.full, "job queue failed to fill")

endmodule

>>> design/sdf_back.sv
`include "signed_decimal_formatter_defines.svh"

module sdf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdf_pkg::job_t         head_job,
  input  sdf_pkg::jq_status_t   jq_status,
  output logic                  jq_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_char_code,
  output logic                  out_is_last,
  output logic [3:0]            out_char_count
);
  import sdf_pkg::*;

  logic                  started_r, started_nxt;
  logic [COUNT_W-1:0]    pos_r, pos_nxt;
  logic                  sign_owed_r, sign_owed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  emit_ok;
  logic [DIGIT_W-1:0]    digit;
  logic [COUNT_W-1:0]    total;

  // The output register may be refilled when it is empty or being taken.
  assign emit_ok = !out_valid_r || out_pop;
  assign digit = head_job.digits[pos_r];
  assign total = head_job.ndig + {{(COUNT_W-1){1'b0}}, head_job.neg};

  // Emitter: set up on a new number, then one character per cycle while the output register may be refilled.
  always_comb begin
    started_nxt = started_r;
    pos_nxt = pos_r;
    sign_owed_nxt = sign_owed_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_count_nxt = out_count_r;
    jq_pop = 1'b0;
    if (!started_r) begin
      if (jq_status.valid) begin
        started_nxt = 1'b1;
        pos_nxt = head_job.ndig - 1'b1;
        sign_owed_nxt = head_job.neg;
      end
    end else if (emit_ok) begin
      out_valid_nxt = 1'b1;
      if (sign_owed_r) begin
        out_char_nxt = CHAR_MINUS;
        out_last_nxt = 1'b0;
        out_count_nxt = '0;
        sign_owed_nxt = 1'b0;
      end else begin
        out_char_nxt = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        if (pos_r == '0) begin
          out_last_nxt = 1'b1;
          out_count_nxt = total;
          started_nxt = 1'b0;
          jq_pop = 1'b1;
        end else begin
          out_last_nxt = 1'b0;
          out_count_nxt = '0;
          pos_nxt = pos_r - 1'b1;
        end
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_char_code = out_char_r;
  assign out_is_last = out_last_r;
  assign out_char_count = out_count_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      sign_owed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      sign_owed_r <= sign_owed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Position and output payload.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  `SDF_ASSERT_SAME(a_pop_on_last, jq_pop, started_r && !sign_owed_r && (pos_r == '0) && emit_ok, "number released before its last digit")
  `SDF_ASSERT_SAME(a_last_is_digit, out_valid_r && out_last_r, (out_char_r >= CHAR_ZERO) && (out_char_r <= CHAR_NINE) && (out_count_r != '0), "final character is not a digit")
  `SDF_ASSERT_SAME(a_count_only_last, out_valid_r && !out_last_r, out_count_r == '0, "character count shown before the final character")

endmodule

>>> design/signed_decimal_formatter.sv
// Prints a signed 32-bit integer as decimal ASCII, one character per result item: an optional
// '-', then the digits most significant first with no leading zeros ('0' for zero). The final
// character has out_is_last set and out_char_count giving the number's length (1 to 11).
// An accepted item passes through a shift-and-add-3 converter that takes 4 magnitude bits
// per cycle, and its digits are then handed to a two-entry job queue; the input side is busy
// until that handoff, which waits while the queue is full. The emitter sets up once per number
// and then produces one character per cycle, while its single output register may be refilled.
// The queue lets the converter work on the next number while the emitter prints the last.
module signed_decimal_formatter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_value,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_char_code,
  output logic                out_is_last,
  output logic [3:0]          out_char_count
);
  import sdf_pkg::*;

  job_t        push_job;
  job_t        head_job;
  jq_status_t  jq_status;
  logic        jq_push;
  logic        jq_pop;

  // Front part: takes items and converts them to decimal digits.
  sdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .jq_full  (jq_status.full),
    .jq_push  (jq_push),
    .jq_job   (push_job)
  );

  // Queue of converted numbers between the two parts.
  sdf_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (push_job),
    .pop      (jq_pop),
    .head_job (head_job),
    .status   (jq_status)
  );

  // Back part: emits the characters of each number.
  sdf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .jq_status      (jq_status),
    .jq_pop         (jq_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_char_code  (out_char_code),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

endmodule

>>> bench/signed_decimal_formatter_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the decimal formatter. Every accepted input item is turned into
// the characters it should print, and every accepted result item is compared with the oldest
// character still owed.
module signed_decimal_formatter_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  logic [31:0]         in_value,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic [7:0]          out_char_code,
  input  logic                out_is_last,
  input  logic [3:0]          out_char_count,
  output int                  mismatches,
  output int                  chars_owed
);
  import sdf_pkg::*;

  // One printed character as the result channel should carry it.
  typedef struct packed {
    logic [CHAR_W-1:0]  code;
    logic               last;
    logic [COUNT_W-1:0] count;
  } char_item_t;

  char_item_t owed_chars[$];
  char_item_t oldest;

  initial begin
    mismatches = 0;
    chars_owed = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Splits the magnitude into decimal digits, least significant first, then queues the
  // sign and the digits in printing order. The magnitude is formed in unsigned arithmetic,
  // so the most negative value prints as its full eleven characters.
  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] value);
    logic [DIGIT_W-1:0] digits [NUM_DIGITS];
    logic [VALUE_W-1:0] magnitude;
    logic               negative;
    logic [COUNT_W-1:0] length;
    int                 ndigits;
    char_item_t         ch;
    negative = value[VALUE_W-1];
    magnitude = negative ? (~value + 1'b1) : value;
    ndigits = 0;
    do begin
      digits[ndigits] = DIGIT_W'(magnitude % 10);
      magnitude = magnitude / 10;
      ndigits++;
    end while (magnitude != 0 && ndigits < NUM_DIGITS);
    length = COUNT_W'(ndigits + (negative ? 1 : 0));
    if (negative) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      ch.count = '0;
      owed_chars.push_back(ch);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
      ch.last = (i == 0);
      ch.count = (i == 0) ? length : '0;
      owed_chars.push_back(ch);
    end
  endfunction

  // Both channels are sampled at the rising edge, before anything driven there takes effect.
  always @(posedge clk) begin
    if (!rst_n) begin
      owed_chars.delete();
    end else begin
      if (in_push && !in_full) begin
        queue_decimal_text(in_value);
      end
      if (out_pop && !out_empty) begin
        if (owed_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h arrived with nothing owed",
                                    out_char_code));
        end else begin
          oldest = owed_chars.pop_front();
          if (out_char_code !== oldest.code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      out_char_code, oldest.code));
          end
          if (out_is_last !== oldest.last) begin
            report_mismatch($sformatf("is_last %0b, expected %0b (char 0x%02h)",
                                      out_is_last, oldest.last, oldest.code));
          end
          if (out_char_count !== oldest.count) begin
            report_mismatch($sformatf("char_count %0d, expected %0d (char 0x%02h)",
                                      out_char_count, oldest.count, oldest.code));
          end
        end
      end
    end
    chars_owed = owed_chars.size();
  end

endmodule

>>> bench/signed_decimal_formatter_tb.sv
`timescale 1ns / 100ps

// Drives numbers into the decimal formatter and pops its characters, with random gaps on
// both sides. All checking is done by the checker; this module gives the verdict.
module signed_decimal_formatter_tb;
  import sdf_pkg::*;

  localparam int RANDOM_ITEMS = 350;
  localparam int CALM_ITEMS = 60;
  localparam int NUM_CORNERS = 22;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [31:0] in_value;
  logic               out_empty;
  logic               out_pop;
  logic [7:0]         out_char_code;
  logic               out_is_last;
  logic [3:0]         out_char_count;
  int                 mismatches;
  int                 chars_owed;
  bit                 calm;

  // Zero, single digits, three changes of length, both extremes and alternating bit patterns.
  logic [31:0] corner_values [NUM_CORNERS] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    -32'sd100, 32'd12345, -32'sd54321, 32'd999999999, 32'd1000000000, -32'sd1000000000,
    32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd1234567890, -32'sd987654321
  };

  signed_decimal_formatter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_value       (in_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_char_code  (out_char_code),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

  signed_decimal_formatter_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_value       (in_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_char_code  (out_char_code),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count),
    .mismatches     (mismatches),
    .chars_owed     (chars_owed)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pushes one item and returns at the edge that accepts it.
  task automatic push_number(input logic [31:0] value);
    in_push <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_full);
  endtask

  // A random gap on the input side, unless the run is in its calm tail.
  task automatic maybe_pause_sender();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      in_value <= $urandom;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Holds the input side idle until every owed character has been popped.
  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
  endtask

  // Most values have a random number of digits so that every length is common; the rest
  // are raw 32-bit patterns.
  function automatic logic [31:0] random_number();
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0]     magnitude;
    int              ndigits;
    if ($urandom_range(0, 9) < 3) begin
      return $urandom;
    end
    ndigits = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < ndigits; i++) lo = lo * 10;
    hi = (ndigits == 1) ? 9 : lo * 10 - 1;
    if (ndigits == 1) lo = 0;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    magnitude = $urandom_range(32'(hi), 32'(lo));
    return $urandom_range(0, 1) ? -magnitude : magnitude;
  endfunction

  // The result side stalls in bursts, except in the calm tail.
  initial begin
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_value = '0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) begin
      push_number(corner_values[i]);
      maybe_pause_sender();
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      push_number(random_number());
      maybe_pause_sender();
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0 && chars_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net should the block hang.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
